// ===== hdl/rms_pkg.sv =====
`timescale 1ns / 1ps

package rms_pkg;

    localparam int VAL_W   = 32;
    localparam int MEAN_W  = 48;
    localparam int DIFF_W  = 49;
    localparam int M2_W    = 64;
    localparam int CNT_W   = 32;
    localparam int DEN_W   = 33;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ROOT_W  = 32;

    localparam logic [1:0] OP_UPDATE    = 2'd0;
    localparam logic [1:0] OP_CLEAR     = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [VAL_W-1:0]  last;
        logic signed [VAL_W-1:0]  min;
        logic signed [VAL_W-1:0]  max;
        logic signed [MEAN_W-1:0] mean;
        logic [M2_W-1:0]          m2;
    } t_entry;

endpackage

// ===== hdl/rms_div.sv =====
`timescale 1ns / 1ps

module rms_div
    import rms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [M2_W-1:0]  i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [M2_W-1:0]  o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(M2_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [M2_W-1:0]   r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    n_trial;
    logic              n_fit;

    assign n_trial = {r_rem, r_quo[M2_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_fit) begin
                    r_rem <= DEN_W'(n_trial - {1'b0, r_den});
                end else begin
                    r_rem <= n_trial[DEN_W-1:0];
                end
                r_quo  <= {r_quo[M2_W-2:0], n_fit};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(M2_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/rms_mul.sv =====
`timescale 1ns / 1ps

module rms_mul
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_a,
    input  logic [DIFF_W-1:0] i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int STEP_W = $clog2(DIFF_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIFF_W-1:0] r_a;
    logic [PROD_W-1:0] r_b;
    logic [PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= i_a;
                r_b    <= PROD_W'(i_b);
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_b;
                end
                r_a    <= r_a >> 1;
                r_b    <= r_b << 1;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/rms_sqrt.sv =====
`timescale 1ns / 1ps

module rms_sqrt
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [M2_W-1:0]   i_x,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [M2_W-1:0]   r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  n_acc;
    logic [REM_W+1:0]  n_trial;
    logic              n_fit;

    assign n_acc   = {r_rem, r_x[M2_W-1:M2_W-2]};
    assign n_trial = (REM_W + 2)'({r_root, 2'b01});
    assign n_fit   = n_acc >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= i_x;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                if (n_fit) begin
                    r_rem <= REM_W'(n_acc - n_trial);
                end else begin
                    r_rem <= REM_W'(n_acc);
                end
                r_root <= {r_root[ROOT_W-2:0], n_fit};
                r_x    <= r_x << 2;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/running_measurement_statistics_top.sv =====
`timescale 1ns / 1ps

// Per-slot running statistics (count, last, min, max, Welford mean and population
// standard deviation) held in one synchronous table of SLOT_COUNT entries; valid bits
// in flip-flops make reset and clear-all immediate. Items are handled one at a time.
// A clear, a clear-all, or a read or dropped update of an empty slot goes straight to
// the output; a read or dropped update of a filled slot first runs the 64-step shared
// divider and the 32-step square root. The first sample into an empty slot and an
// update at saturated count are written back and then take that same path. Any other
// accumulating update first adds the 64-step mean division on the divider and the
// serial product. A new word is taken as soon as the previous one has been handed
// to the output register.

module running_measurement_statistics_top
    import rms_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // slot[3:0], sample_value[35:4], zero fill
    input  logic [1:0]   s_axis_tuser,   // opcode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // count, current, min, max, mean, std_deviation
    output logic         m_axis_tuser    // update_ignored
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_EVAL = 4'd2;
    localparam logic [3:0] S_DIVM = 4'd3;
    localparam logic [3:0] S_D2   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_WB   = 4'd6;
    localparam logic [3:0] S_STD  = 4'd7;
    localparam logic [3:0] S_DIVS = 4'd8;
    localparam logic [3:0] S_SQRT = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    t_entry r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;

    logic              r_en;
    logic [3:0]        r_state;
    logic [1:0]        r_op;
    logic [AW-1:0]     r_addr;
    logic              r_ok;
    logic signed [VAL_W-1:0] r_x;
    logic              r_ign;
    t_entry            r_rd;
    logic              r_rvld;
    t_entry            r_w;
    logic              r_neg;
    logic [DIFF_W-1:0] r_d1;
    logic [DEN_W-1:0]  r_n;
    logic [ROOT_W-1:0] r_std;

    logic              r_ovalid;
    logic [191:0]      r_odata;
    logic              r_ouser;

    logic [8:0]        n_slot;
    t_entry            n_cur;
    logic [MEAN_W-1:0] n_xs;
    logic [DIFF_W-1:0] n_diff1;
    logic [DIFF_W-1:0] n_d1;
    logic [DIFF_W-1:0] n_diff2;
    logic [DIFF_W-1:0] n_d2;
    logic              n_div_start;
    logic [M2_W-1:0]   n_div_num;
    logic [DEN_W-1:0]  n_div_den;
    logic              n_eval_div;
    logic [DIFF_W-1:0] n_q;
    logic [DIFF_W-1:0] n_mean;
    logic [PROD_W-1:0] n_prod_rnd;
    logic [M2_W-1:0]   n_inc;
    logic [M2_W:0]     n_m2sum;
    logic [DIFF_W-1:0] n_mean_rnd;
    logic              n_load;

    logic              w_div_done;
    logic [M2_W-1:0]   w_div_quo;
    logic [DEN_W-1:0]  w_div_rem;
    logic              w_mul_done;
    logic [PROD_W-1:0] w_mul_prod;
    logic              w_sqrt_done;
    logic [ROOT_W-1:0] w_sqrt_root;

    assign n_slot = {5'b0, s_axis_tdata[3:0]};
    assign n_cur  = (r_rvld && r_ok) ? r_rd : '0;
    assign n_xs   = {r_x, 16'b0};

    assign n_diff1 = {n_xs[MEAN_W-1], n_xs} - {n_cur.mean[MEAN_W-1], n_cur.mean};
    assign n_d1    = n_diff1[DIFF_W-1] ? DIFF_W'(-n_diff1) : n_diff1;
    assign n_diff2 = {n_xs[MEAN_W-1], n_xs} - {r_w.mean[MEAN_W-1], r_w.mean};
    assign n_d2    = n_diff2[DIFF_W-1] ? DIFF_W'(-n_diff2) : n_diff2;

    assign n_eval_div = (r_op == OP_UPDATE) && r_en && r_ok && (n_cur.count != '0)
                        && (n_cur.count != CNT_MAX);
    assign n_div_start = ((r_state == S_EVAL) && n_eval_div) || (r_state == S_STD);
    assign n_div_num   = (r_state == S_EVAL) ? M2_W'(n_d1) : r_w.m2;
    assign n_div_den   = (r_state == S_EVAL) ? DEN_W'({1'b0, n_cur.count} + 1'b1)
                                             : {1'b0, r_w.count};

    assign n_q = w_div_quo[DIFF_W-1:0]
                 + DIFF_W'({w_div_rem, 1'b0} >= {1'b0, r_n});
    assign n_mean = r_neg ? {r_w.mean[MEAN_W-1], r_w.mean} - n_q
                          : {r_w.mean[MEAN_W-1], r_w.mean} + n_q;

    assign n_prod_rnd = w_mul_prod + PROD_W'(32'h8000_0000);
    assign n_inc      = (n_prod_rnd[PROD_W-1:M2_W+32] != '0) ? '1
                                                              : n_prod_rnd[M2_W+31:32];
    assign n_m2sum    = {1'b0, r_w.m2} + {1'b0, n_inc};

    assign n_mean_rnd = {r_w.mean[MEAN_W-1], r_w.mean} + DIFF_W'(17'h08000);
    assign n_load     = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    rms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    rms_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_D2),
        .i_a     (r_d1),
        .i_b     (n_d2),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    rms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DIVS) && w_div_done),
        .i_x     (w_div_quo),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    // table port
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd <= r_mem[r_addr];
        end
        if (r_state == S_WB) begin
            r_mem[r_addr] <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_en <= i_cfg_wdata;
            end
            if (n_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_addr  <= n_slot[AW-1:0];
                        r_ok    <= n_slot < 9'(SLOT_COUNT);
                        r_x     <= s_axis_tdata[35:4];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rvld  <= r_vld[r_addr];
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_ign <= (r_op == OP_UPDATE) && !r_en;
                    r_std <= '0;
                    r_w   <= n_cur;
                    case (r_op)
                        OP_CLEAR_ALL: begin
                            r_vld   <= '0;
                            r_w     <= '0;
                            r_state <= S_OUT;
                        end
                        OP_CLEAR: begin
                            if (r_ok) begin
                                r_vld[r_addr] <= 1'b0;
                            end
                            r_w     <= '0;
                            r_state <= S_OUT;
                        end
                        OP_UPDATE: begin
                            if (!r_en || !r_ok) begin
                                r_state <= (n_cur.count != '0) ? S_STD : S_OUT;
                            end else if (n_cur.count == '0) begin
                                r_w.count <= CNT_W'(1);
                                r_w.last  <= r_x;
                                r_w.min   <= r_x;
                                r_w.max   <= r_x;
                                r_w.mean  <= n_xs;
                                r_w.m2    <= '0;
                                r_state   <= S_WB;
                            end else begin
                                r_w.last <= r_x;
                                if (r_x < n_cur.min) begin
                                    r_w.min <= r_x;
                                end
                                if (r_x > n_cur.max) begin
                                    r_w.max <= r_x;
                                end
                                r_neg   <= n_diff1[DIFF_W-1];
                                r_d1    <= n_d1;
                                r_n     <= n_div_den;
                                r_state <= n_eval_div ? S_DIVM : S_WB;
                            end
                        end
                        default: begin
                            r_state <= (n_cur.count != '0) ? S_STD : S_OUT;
                        end
                    endcase
                end
                S_DIVM: begin
                    if (w_div_done) begin
                        r_w.mean <= n_mean[MEAN_W-1:0];
                        r_state  <= S_D2;
                    end
                end
                S_D2: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_w.m2    <= n_m2sum[M2_W] ? '1 : n_m2sum[M2_W-1:0];
                        r_w.count <= r_n[CNT_W-1:0];
                        r_state   <= S_WB;
                    end
                end
                S_WB: begin
                    r_vld[r_addr] <= 1'b1;
                    r_state       <= S_STD;
                end
                S_STD: begin
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    if (w_div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_std   <= w_sqrt_root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_odata <= {r_std, n_mean_rnd[MEAN_W-1:16], r_w.max, r_w.min, r_w.last,
                        r_w.count};
            r_ouser <= r_ign;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
